// ===== rtl/core/lpip_pkg.sv =====
package lpip_pkg;

  // Ring count for the blue channel scale
  localparam int RING_COUNT = 32;
  localparam int CHAN_MAX   = 255;

  // Coefficient and coordinate formats
  localparam int COEF_W = 20;
  localparam int CFG_W  = 3 * COEF_W;
  localparam int PT_W   = 16;
  localparam int PROD_W = COEF_W + PT_W;
  localparam int OFFS_W = COEF_W + 8;
  localparam int ACC_W  = PROD_W + 2;
  localparam int NUM_W  = ACC_W + 2;
  localparam int Q_W    = 17;
  localparam int SH_W   = NUM_W + Q_W + 1;

  localparam logic [Q_W-1:0] Q_POS_MAX = Q_W'(32767);
  localparam logic [Q_W-1:0] Q_NEG_MAX = Q_W'(32768);

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DROP  = 2'd1;
  localparam logic [1:0] ST_DEPTH = 2'd2;

  // Register indexes
  localparam logic [7:0] REG_ROW0   = 8'd0;
  localparam logic [7:0] REG_ROW1   = 8'd1;
  localparam logic [7:0] REG_ROW2   = 8'd2;
  localparam logic [7:0] REG_OFFSET = 8'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] blue;
    logic [7:0] green;
  } side_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] s;
    side_t                   side;
  } acc_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem_a;
    logic [NUM_W-1:0] rem_b;
    logic [NUM_W-1:0] den;
    logic [Q_W-1:0]   q_a;
    logic [Q_W-1:0]   q_b;
    logic             ovf_a;
    logic             ovf_b;
    logic             neg_a;
    logic             neg_b;
    side_t            side;
  } div_st_t;

  // ring*255/RING_COUNT, clamped to one color channel
  function automatic logic [7:0] ring_blue(input logic [4:0] ring);
    logic [15:0] prod;
    logic [15:0] quo;
    begin
      prod = 16'(ring) * 16'(CHAN_MAX);
      quo  = prod / 16'(RING_COUNT);
      ring_blue = (quo > 16'(CHAN_MAX)) ? 8'(CHAN_MAX) : quo[7:0];
    end
  endfunction

  // 2*intensity, clamped
  function automatic logic [7:0] inten_green(input logic [7:0] inten);
    logic [8:0] dbl;
    begin
      dbl = {inten, 1'b0};
      inten_green = (dbl > 9'(CHAN_MAX)) ? 8'(CHAN_MAX) : dbl[7:0];
    end
  endfunction

endpackage

// ===== rtl/core/lidar_point_image_projection.sv =====
// Throughput: one point per cycle; the whole pipeline freezes while out_valid
// is high and out_ready low. Depth is set by the 17 restoring divider stages.
// Reset (synchronous, rst_n low): all pipeline valid bits cleared, projection
// registers cleared to zero. Config port is always ready.
module lidar_point_image_projection (
  input  logic                               clk,
  input  logic                               rst_n,
  // point input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [lpip_pkg::PT_W-1:0]   in_point_x,
  input  logic signed [lpip_pkg::PT_W-1:0]   in_point_y,
  input  logic signed [lpip_pkg::PT_W-1:0]   in_point_z,
  input  logic [7:0]                         in_intensity,
  input  logic [4:0]                         in_ring,
  // pixel result
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_status,
  output logic signed [15:0]                 out_pixel_u,
  output logic signed [15:0]                 out_pixel_v,
  output logic [7:0]                         out_blue,
  output logic [7:0]                         out_green,
  // register writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [7:0]                         cfg_index,
  input  logic [lpip_pkg::CFG_W-1:0]         cfg_data
);
  import lpip_pkg::*;

  // projection matrix and offsets
  logic [CFG_W-1:0] row0_r;
  logic [CFG_W-1:0] row1_r;
  logic [CFG_W-1:0] row2_r;
  logic [CFG_W-1:0] offs_r;

  logic             adv;
  side_t            in_side;
  logic             mac_vld;
  acc_t             mac_acc;

  // prep stage
  div_st_t          prep_nxt;
  div_st_t          prep_r;
  logic             prep_vld_r;
  logic [ACC_W-1:0] mag_a;
  logic [ACC_W-1:0] mag_b;

  logic             div_vld;
  div_st_t          div_op;

  // output register
  logic             out_valid_r;
  logic [1:0]       status_r,  status_nxt;
  logic [15:0]      u_r,       u_nxt;
  logic [15:0]      v_r,       v_nxt;
  logic [7:0]       blue_r;
  logic [7:0]       green_r;

  // Global stall: every stage moves together unless the output beat is stuck.
  assign adv       = out_ready || !out_valid_r;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Register writes; unknown indexes are dropped
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row0_r <= '0;
      row1_r <= '0;
      row2_r <= '0;
      offs_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW0:   row0_r <= cfg_data;
        REG_ROW1:   row1_r <= cfg_data;
        REG_ROW2:   row2_r <= cfg_data;
        REG_OFFSET: offs_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sideband: drop flag and colors are settled at entry and ride along
  // ---------------------------------------------------------------------------
  always_comb begin
    in_side.status = in_point_x[PT_W-1] ? ST_DROP : ST_OK;
    in_side.blue   = ring_blue(in_ring);
    in_side.green  = inten_green(in_intensity);
  end

  // stages 1-2: products and row sums a, b, s
  lpip_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .pt_x    (in_point_x),
    .pt_y    (in_point_y),
    .pt_z    (in_point_z),
    .in_side (in_side),
    .row0    (row0_r),
    .row1    (row1_r),
    .row2    (row2_r),
    .offs    (offs_r),
    .out_vld (mac_vld),
    .out_acc (mac_acc)
  );

  // ---------------------------------------------------------------------------
  // Stage 3: round-to-nearest becomes floor((2|n| + s) / 2s); depth check
  // ---------------------------------------------------------------------------
  always_comb begin
    mag_a = mac_acc.a[ACC_W-1] ? ACC_W'(-mac_acc.a) : ACC_W'(mac_acc.a);
    mag_b = mac_acc.b[ACC_W-1] ? ACC_W'(-mac_acc.b) : ACC_W'(mac_acc.b);
    prep_nxt       = '0;
    prep_nxt.rem_a = {1'b0, mag_a, 1'b0} + {2'b00, mac_acc.s};
    prep_nxt.rem_b = {1'b0, mag_b, 1'b0} + {2'b00, mac_acc.s};
    prep_nxt.den   = {1'b0, mac_acc.s, 1'b0};
    prep_nxt.neg_a = mac_acc.a[ACC_W-1];
    prep_nxt.neg_b = mac_acc.b[ACC_W-1];
    prep_nxt.side  = mac_acc.side;
    if (mac_acc.side.status == ST_OK &&
        (mac_acc.s[ACC_W-1] || mac_acc.s == '0)) begin
      prep_nxt.side.status = ST_DEPTH;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
    end else if (adv) begin
      prep_vld_r <= mac_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prep_r <= prep_nxt;
    end
  end

  // stages 4-21: overflow check and bit-per-stage division
  lpip_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (prep_vld_r),
    .in_op   (prep_r),
    .out_vld (div_vld),
    .out_op  (div_op)
  );

  // ---------------------------------------------------------------------------
  // Stage 22: sign, saturate, zero the pixel for non-projected points
  // ---------------------------------------------------------------------------
  always_comb begin
    status_nxt = div_op.side.status;
    u_nxt      = '0;
    v_nxt      = '0;
    if (div_op.side.status == ST_OK) begin
      if (div_op.neg_a) begin
        u_nxt = (div_op.ovf_a || div_op.q_a > Q_NEG_MAX) ? 16'h8000 : 16'(-div_op.q_a);
      end else begin
        u_nxt = (div_op.ovf_a || div_op.q_a > Q_POS_MAX) ? 16'h7fff : div_op.q_a[15:0];
      end
      if (div_op.neg_b) begin
        v_nxt = (div_op.ovf_b || div_op.q_b > Q_NEG_MAX) ? 16'h8000 : 16'(-div_op.q_b);
      end else begin
        v_nxt = (div_op.ovf_b || div_op.q_b > Q_POS_MAX) ? 16'h7fff : div_op.q_b[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status_r <= status_nxt;
      u_r      <= u_nxt;
      v_r      <= v_nxt;
      blue_r   <= div_op.side.blue;
      green_r  <= div_op.side.green;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = status_r;
  assign out_pixel_u = $signed(u_r);
  assign out_pixel_v = $signed(v_r);
  assign out_blue    = blue_r;
  assign out_green   = green_r;

endmodule

// ===== rtl/core/lpip_mac.sv =====
module lpip_mac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_vld,
  input  logic signed [lpip_pkg::PT_W-1:0]    pt_x,
  input  logic signed [lpip_pkg::PT_W-1:0]    pt_y,
  input  logic signed [lpip_pkg::PT_W-1:0]    pt_z,
  input  lpip_pkg::side_t                     in_side,
  input  logic [lpip_pkg::CFG_W-1:0]          row0,
  input  logic [lpip_pkg::CFG_W-1:0]          row1,
  input  logic [lpip_pkg::CFG_W-1:0]          row2,
  input  logic [lpip_pkg::CFG_W-1:0]          offs,
  output logic                                out_vld,
  output lpip_pkg::acc_t                      out_acc
);
  import lpip_pkg::*;

  logic [CFG_W-1:0]         rows [3];
  logic signed [PROD_W-1:0] prod_nxt [9];
  logic signed [PROD_W-1:0] prod_r   [9];
  logic signed [OFFS_W-1:0] offs_nxt [3];
  logic signed [OFFS_W-1:0] offs_r   [3];
  side_t                    side1_r;
  logic                     vld1_r;
  acc_t                     acc_nxt;
  acc_t                     acc_r;
  logic                     vld2_r;
  logic signed [ACC_W-1:0]  sum_nxt [3];

  assign rows[0] = row0;
  assign rows[1] = row1;
  assign rows[2] = row2;

  // stage 1: nine products, offsets scaled to the product format
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      prod_nxt[3*r]   = $signed(rows[r][COEF_W-1:0]) * pt_x;
      prod_nxt[3*r+1] = $signed(rows[r][2*COEF_W-1:COEF_W]) * pt_y;
      prod_nxt[3*r+2] = $signed(rows[r][3*COEF_W-1:2*COEF_W]) * pt_z;
      offs_nxt[r]     = $signed({offs[COEF_W*r +: COEF_W], 8'b0});
    end
  end

  // stage 2: row sums
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt[r] = ACC_W'(prod_r[3*r]) + ACC_W'(prod_r[3*r+1])
                 + ACC_W'(prod_r[3*r+2]) + ACC_W'(offs_r[r]);
    end
    acc_nxt.a    = sum_nxt[0];
    acc_nxt.b    = sum_nxt[1];
    acc_nxt.s    = sum_nxt[2];
    acc_nxt.side = side1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r  <= prod_nxt;
      offs_r  <= offs_nxt;
      side1_r <= in_side;
      acc_r   <= acc_nxt;
    end
  end

  assign out_vld = vld2_r;
  assign out_acc = acc_r;

endmodule

// ===== rtl/core/lpip_div.sv =====
module lpip_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  lpip_pkg::div_st_t in_op,
  output logic              out_vld,
  output lpip_pkg::div_st_t out_op
);
  import lpip_pkg::*;

  // stage 0 flags quotients of 2^Q_W or more, then one quotient bit per stage
  div_st_t          pipe_nxt [Q_W+1];
  div_st_t          pipe_r   [Q_W+1];
  logic [Q_W:0]     vld_r;
  logic [SH_W-1:0]  lim;
  logic [SH_W-1:0]  dsh;

  always_comb begin
    lim         = SH_W'(in_op.den) << Q_W;
    pipe_nxt[0] = in_op;
    pipe_nxt[0].ovf_a = SH_W'(in_op.rem_a) >= lim;
    pipe_nxt[0].ovf_b = SH_W'(in_op.rem_b) >= lim;
    pipe_nxt[0].q_a   = '0;
    pipe_nxt[0].q_b   = '0;
    dsh = '0;
    for (int i = 0; i < Q_W; i++) begin
      pipe_nxt[i+1] = pipe_r[i];
      dsh = SH_W'(pipe_r[i].den) << (Q_W - 1 - i);
      if (SH_W'(pipe_r[i].rem_a) >= dsh) begin
        pipe_nxt[i+1].rem_a = NUM_W'(SH_W'(pipe_r[i].rem_a) - dsh);
        pipe_nxt[i+1].q_a[Q_W-1-i] = 1'b1;
      end
      if (SH_W'(pipe_r[i].rem_b) >= dsh) begin
        pipe_nxt[i+1].rem_b = NUM_W'(SH_W'(pipe_r[i].rem_b) - dsh);
        pipe_nxt[i+1].q_b[Q_W-1-i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Q_W-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pipe_r <= pipe_nxt;
    end
  end

  assign out_vld = vld_r[Q_W];
  assign out_op  = pipe_r[Q_W];

endmodule
